>>> src/b64c_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types, character codes and alphabet functions for the base64 codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  localparam logic [7:0] CHAR_PAD = 8'h3D;   // '='
  localparam logic [7:0] CHAR_NL  = 8'h0A;   // newline

  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);

  // One unit of work for the back end: a completed group and how to emit it.
  typedef struct packed {
    logic [23:0] bits;
    logic        dec;
    logic [2:0]  n_real;  // data characters or bytes
    logic [1:0]  n_pad;   // '=' characters after the data
    logic        nl;      // trailing newline
    logic        bad;
    logic        last;
  } b64c_job_t;

  // Sextet to alphabet character.
  function automatic logic [7:0] enc_char(input logic [5:0] s);
    logic [7:0] s8;
    s8 = {2'b00, s};
    if (s < 6'd26)      return 8'(8'h41 + s8);
    else if (s < 6'd52) return 8'(8'h61 + s8 - 8'd26);
    else if (s < 6'd62) return 8'(8'h30 + s8 - 8'd52);
    else if (s == 6'd62) return 8'h2B;
    else                return 8'h2F;
  endfunction

  // Character to sextet; bit 6 set when the character is outside the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    if (c inside {[8'h41:8'h5A]})      return {1'b0, 6'(c - 8'h41)};
    else if (c inside {[8'h61:8'h7A]}) return {1'b0, 6'(c - 8'h61 + 8'd26)};
    else if (c inside {[8'h30:8'h39]}) return {1'b0, 6'(c - 8'h30 + 8'd52)};
    else if (c == 8'h2B)               return {1'b0, 6'd62};
    else if (c == 8'h2F)               return {1'b0, 6'd63};
    else                               return 7'h40;
  endfunction

endpackage

>>> src/b64c_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_front
// Accepts input requests, gathers groups and issues a job per finished group.
// ----------------------------------------------------------------------------
module b64c_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tlast,
  input  logic                full_i,
  output logic                push_o,
  output b64c_pkg::b64c_job_t job_o
);
  import b64c_pkg::*;

  logic        mode_r;
  logic [23:0] bits_r, bits_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic        bad_r, bad_nxt;

  logic        accept;
  logic [23:0] merged;
  logic [1:0]  cnt_inc;
  logic [6:0]  sext;
  logic [5:0]  v;
  logic [1:0]  pad_inc;
  logic        bad_inc;

  assign in_tready = !full_i;
  assign accept    = in_tvalid && !full_i;

  always_comb begin
    bits_nxt = bits_r;
    cnt_nxt  = cnt_r;
    pad_nxt  = pad_r;
    bad_nxt  = bad_r;
    job_o    = '0;
    push_o   = 1'b0;
    sext     = sextet_of(in_tdata);
    v        = sext[6] ? 6'd0 : sext[5:0];
    pad_inc  = pad_r;
    bad_inc  = bad_r;
    cnt_inc  = 2'(cnt_r + 2'd1);
    case (cnt_r)
      2'd0:    merged = bits_r | {in_tdata, 16'h0};
      2'd1:    merged = bits_r | {8'h0, in_tdata, 8'h0};
      default: merged = bits_r | {16'h0, in_tdata};
    endcase
    job_o.last = in_tlast;

    if (accept) begin
      if (mode_r == MODE_ENC) begin
        job_o.bits = merged;
        job_o.dec  = 1'b0;
        if (cnt_r >= 2'd2) begin
          job_o.n_real = 3'd4;
          job_o.nl     = in_tlast;
          push_o       = 1'b1;
          bits_nxt     = '0;
          cnt_nxt      = '0;
        end else if (in_tlast) begin
          // pad the short group and close the message
          job_o.n_real = (cnt_inc == 2'd2) ? 3'd3 : 3'd2;
          job_o.n_pad  = (cnt_inc == 2'd2) ? 2'd1 : 2'd2;
          job_o.nl     = 1'b1;
          push_o       = 1'b1;
          bits_nxt     = '0;
          cnt_nxt      = '0;
        end else begin
          bits_nxt = merged;
          cnt_nxt  = cnt_inc;
        end
      end else begin
        if (in_tdata != CHAR_NL) begin
          if (in_tdata == CHAR_PAD) begin
            v = 6'd0;
            if (pad_r != 2'd3) pad_inc = 2'(pad_r + 2'd1);
          end else if (sext[6]) begin
            bad_inc = 1'b1;
          end
          job_o.bits = {bits_r[17:0], v};
          job_o.dec  = 1'b1;
          job_o.bad  = bad_inc;
          if (cnt_r == 2'd3) begin
            job_o.n_real = 3'(2'd3 - pad_inc);
            push_o       = (pad_inc != 2'd3);
            bits_nxt     = '0;
            cnt_nxt      = '0;
            pad_nxt      = '0;
            bad_nxt      = 1'b0;
          end else begin
            bits_nxt = {bits_r[17:0], v};
            cnt_nxt  = cnt_inc;
            pad_nxt  = pad_inc;
            bad_nxt  = bad_inc;
          end
        end
        if (in_tlast) begin
          // drop any short group
          bits_nxt = '0;
          cnt_nxt  = '0;
          pad_nxt  = '0;
          bad_nxt  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENC;
      bits_r <= '0;
      cnt_r  <= '0;
      pad_r  <= '0;
      bad_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
      bits_r <= '0;
      cnt_r  <= '0;
      pad_r  <= '0;
      bad_r  <= 1'b0;
    end else begin
      bits_r <= bits_nxt;
      cnt_r  <= cnt_nxt;
      pad_r  <= pad_nxt;
      bad_r  <= bad_nxt;
    end
  end

endmodule

>>> src/b64c_jobq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_jobq
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module b64c_jobq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  b64c_pkg::b64c_job_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                head_valid_o,
  output b64c_pkg::b64c_job_t head_o
);
  import b64c_pkg::*;

  b64c_job_t            mem_r [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [JOBQ_AW:0]     cnt_r;

  assign full_o       = (cnt_r == (JOBQ_AW + 1)'(JOBQ_DEPTH));
  assign head_valid_o = (cnt_r != '0);
  assign head_o       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_ptr_r] <= push_data_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_i) wr_ptr_r <= JOBQ_AW'(wr_ptr_r + 1'b1);
      if (pop_i)  rd_ptr_r <= JOBQ_AW'(rd_ptr_r + 1'b1);
      if (push_i && !pop_i)      cnt_r <= (JOBQ_AW + 1)'(cnt_r + 1'b1);
      else if (pop_i && !push_i) cnt_r <= (JOBQ_AW + 1)'(cnt_r - 1'b1);
    end
  end

endmodule

>>> src/b64c_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_back
// Walks the head job into the output register, one result per unstalled cycle.
// ----------------------------------------------------------------------------
module b64c_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid_i,
  input  b64c_pkg::b64c_job_t head_i,
  output logic                pop_o,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast,
  output logic                out_tuser
);
  import b64c_pkg::*;

  logic [2:0] idx_r;
  logic [2:0] total;
  logic [2:0] pad_end;
  logic       load;
  logic       at_end;
  logic [5:0] sext;
  logic [7:0] dbyte;
  logic [7:0] ch;

  logic       out_tvalid_r;
  logic [7:0] out_tdata_r;
  logic       out_tlast_r;
  logic       out_tuser_r;

  assign pad_end = 3'(head_i.n_real + {1'b0, head_i.n_pad});
  assign total   = 3'(pad_end + {2'b0, head_i.nl});
  assign at_end  = (idx_r == 3'(total - 3'd1));
  assign load    = head_valid_i && (!out_tvalid_r || out_tready);
  assign pop_o   = load && at_end;

  always_comb begin
    case (idx_r[1:0])
      2'd0:    sext = head_i.bits[23:18];
      2'd1:    sext = head_i.bits[17:12];
      2'd2:    sext = head_i.bits[11:6];
      default: sext = head_i.bits[5:0];
    endcase
    case (idx_r[1:0])
      2'd0:    dbyte = head_i.bits[23:16];
      2'd1:    dbyte = head_i.bits[15:8];
      default: dbyte = head_i.bits[7:0];
    endcase
    if (idx_r < head_i.n_real) ch = head_i.dec ? dbyte : enc_char(sext);
    else if (idx_r < pad_end)  ch = CHAR_PAD;
    else                       ch = CHAR_NL;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tdata_r <= ch;
      out_tlast_r <= head_i.last && at_end;
      out_tuser_r <= head_i.dec && head_i.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      if (load)            out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
      if (load) idx_r <= at_end ? 3'd0 : 3'(idx_r + 3'd1);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

endmodule

>>> src/base64_codec_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_codec_core
// Streaming base64 encoder/decoder with the standard alphabet.
// ----------------------------------------------------------------------------
// The front end takes one input request per cycle while its job queue has
// room; the back end emits one result per cycle from the queue head through
// an output register while out_tready does not stall it. A result passes
// through the job queue and then the output register. The single result
// port sets the rate: encoding emits four characters per three bytes, with
// padding and a newline added to the final group, and decoding sustains one
// character per cycle. Write cfg_wr_data (0 encode, 1 decode) only while
// the block is idle; the write discards any partial group. out_tuser flags
// decoded bytes from a group that held a character outside the alphabet.
module base64_codec_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,   // mode
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [7:0] data_byte
  input  logic       in_tlast,      // last_item
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,     // [7:0] out_byte
  output logic       out_tlast,     // last_out
  output logic       out_tuser      // [0] bad_char
);
  import b64c_pkg::*;

  logic      push;
  logic      full;
  logic      pop;
  logic      head_valid;
  b64c_job_t job;
  b64c_job_t head;

  b64c_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .full_i      (full),
    .push_o      (push),
    .job_o       (job)
  );

  b64c_jobq u_jobq (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_i       (push),
    .push_data_i  (job),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  b64c_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tuser    (out_tuser)
  );

endmodule
